// ----- rtl/uart_rx_8n1_with_timeout_assert.svh -----
// Assertion macros used by the receiver top level.
`ifndef UART_RX_8N1_WITH_TIMEOUT_ASSERT_SVH
`define UART_RX_8N1_WITH_TIMEOUT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define URX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define URX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/urx_pkg.sv -----
package urx_pkg;

    localparam int C_DATA_BITS = 8;

    localparam int C_BIT_W     = 16;
    localparam int C_WAIT_W    = 24;
    localparam int C_CNT_W     = 4;
    localparam int C_BYTE_W    = 8;
    localparam int C_CFG_IDX_W = 2;
    localparam int C_CFG_DAT_W = 24;

    localparam logic [C_BIT_W-1:0]  C_BIT_TICKS_RST  = 16'd16;
    localparam logic [C_BIT_W-1:0]  C_HALF_TICKS_RST = 16'd8;
    localparam logic [C_WAIT_W-1:0] C_TIMEOUT_RST    = 24'd1000000;

    localparam logic [C_CFG_IDX_W-1:0] C_CFG_BIT_TICKS  = 2'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_CFG_HALF_TICKS = 2'd1;
    localparam logic [C_CFG_IDX_W-1:0] C_CFG_TIMEOUT    = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WAIT_HIGH = 3'd1,
        PH_WAIT_EDGE = 3'd2,
        PH_HALF      = 3'd3,
        PH_BITS      = 3'd4
    } t_phase;

    typedef struct packed {
        logic start_req;
        logic rx_level;
    } t_item;

    typedef struct packed {
        logic                emit;
        logic [C_BYTE_W-1:0] data;
        logic                timed_out;
    } t_result;

endpackage

// ----- rtl/urx_in_reg.sv -----
module urx_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  urx_pkg::t_item i_item,
    input  logic          i_drain,
    output logic          o_valid,
    output urx_pkg::t_item o_item
);
    import urx_pkg::*;

    logic  r_valid;
    t_item r_item;

    // take a new beat when empty or when the held one moves on this cycle
    assign o_ready = !r_valid || i_drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- rtl/urx_core.sv -----
module urx_core #(
    parameter int DATA_BITS = urx_pkg::C_DATA_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [urx_pkg::C_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [urx_pkg::C_CFG_DAT_W-1:0]  i_cfg_wdata,
    input  logic                             i_step,
    input  urx_pkg::t_item                   i_item,
    output urx_pkg::t_result                 o_result
);
    import urx_pkg::*;

    localparam logic [C_CNT_W-1:0] C_NBITS = C_CNT_W'(DATA_BITS);

    logic [C_BIT_W-1:0]  r_bit_ticks;
    logic [C_BIT_W-1:0]  r_half_ticks;
    logic [C_WAIT_W-1:0] r_timeout;

    t_phase              r_phase, n_phase;
    logic [C_BIT_W-1:0]  r_bit_timer, n_bit_timer;
    logic [C_WAIT_W-1:0] r_wait_timer, n_wait_timer;
    logic [C_CNT_W-1:0]  r_bits_left, n_bits_left;
    logic [C_BYTE_W-1:0] r_shift, n_shift;

    // working copy after a request has restarted the search
    t_phase              e_phase;
    logic [C_BIT_W-1:0]  e_bit_timer;
    logic [C_WAIT_W-1:0] e_wait_timer;
    logic [C_CNT_W-1:0]  e_bits_left;
    logic [C_BYTE_W-1:0] e_shift;

    logic [C_BIT_W-1:0]  w_period;
    logic [C_BIT_W-1:0]  w_bit_dec;
    logic [C_WAIT_W-1:0] w_wait_inc;
    logic                w_expired;
    logic [C_CNT_W-1:0]  w_left_dec;
    logic [C_CNT_W-1:0]  w_pos;
    logic [C_BYTE_W-1:0] w_sampled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_ticks  <= C_BIT_TICKS_RST;
            r_half_ticks <= C_HALF_TICKS_RST;
            r_timeout    <= C_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                C_CFG_BIT_TICKS:  r_bit_ticks  <= i_cfg_wdata[C_BIT_W-1:0];
                C_CFG_HALF_TICKS: r_half_ticks <= i_cfg_wdata[C_BIT_W-1:0];
                C_CFG_TIMEOUT:    r_timeout    <= i_cfg_wdata[C_WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign e_phase      = i_item.start_req ? PH_WAIT_HIGH : r_phase;
    assign e_bit_timer  = i_item.start_req ? '0 : r_bit_timer;
    assign e_wait_timer = i_item.start_req ? '0 : r_wait_timer;
    assign e_bits_left  = i_item.start_req ? '0 : r_bits_left;
    assign e_shift      = i_item.start_req ? '0 : r_shift;

    assign w_period   = (r_bit_ticks == '0) ? C_BIT_W'(1) : r_bit_ticks;
    assign w_bit_dec  = e_bit_timer - C_BIT_W'(1);
    assign w_wait_inc = e_wait_timer + C_WAIT_W'(1);
    assign w_expired  = (w_wait_inc >= r_timeout);
    assign w_left_dec = e_bits_left - C_CNT_W'(1);
    assign w_pos      = C_NBITS - e_bits_left;

    always_comb begin
        w_sampled = e_shift;
        // bits past the eighth are sampled but dropped
        if (i_item.rx_level && (w_pos < C_CNT_W'(C_BYTE_W))) begin
            w_sampled[w_pos[2:0]] = 1'b1;
        end
    end

    // next phase
    always_comb begin
        n_phase = e_phase;
        case (e_phase)
            PH_WAIT_HIGH: begin
                if (i_item.rx_level) begin
                    n_phase = PH_WAIT_EDGE;
                end else if (w_expired) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_WAIT_EDGE: begin
                if (!i_item.rx_level) begin
                    n_phase = (r_half_ticks == '0) ? PH_BITS : PH_HALF;
                end else if (w_expired) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_HALF: begin
                if (w_bit_dec == '0) begin
                    n_phase = PH_BITS;
                end
            end
            PH_BITS: begin
                if (w_bit_dec == '0 && w_left_dec == '0) begin
                    n_phase = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // datapath and result
    always_comb begin
        n_bit_timer  = e_bit_timer;
        n_wait_timer = e_wait_timer;
        n_bits_left  = e_bits_left;
        n_shift      = e_shift;
        o_result     = '0;
        case (e_phase)
            PH_WAIT_HIGH: begin
                if (i_item.rx_level) begin
                    n_wait_timer = '0;
                end else if (w_expired) begin
                    n_wait_timer       = '0;
                    o_result.emit      = 1'b1;
                    o_result.timed_out = 1'b1;
                end else begin
                    n_wait_timer = w_wait_inc;
                end
            end
            PH_WAIT_EDGE: begin
                if (!i_item.rx_level) begin
                    n_wait_timer = '0;
                    n_bits_left  = C_NBITS;
                    n_shift      = '0;
                    n_bit_timer  = (r_half_ticks == '0) ? w_period : r_half_ticks;
                end else if (w_expired) begin
                    n_wait_timer       = '0;
                    o_result.emit      = 1'b1;
                    o_result.timed_out = 1'b1;
                end else begin
                    n_wait_timer = w_wait_inc;
                end
            end
            PH_HALF: begin
                n_bit_timer = (w_bit_dec == '0) ? w_period : w_bit_dec;
            end
            PH_BITS: begin
                if (w_bit_dec != '0) begin
                    n_bit_timer = w_bit_dec;
                end else begin
                    n_shift     = w_sampled;
                    n_bits_left = w_left_dec;
                    if (w_left_dec != '0) begin
                        n_bit_timer = w_period;
                    end else begin
                        n_bit_timer   = '0;
                        o_result.emit = 1'b1;
                        o_result.data = w_sampled;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_timer  <= '0;
            r_wait_timer <= '0;
            r_bits_left  <= '0;
            r_shift      <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bit_timer  <= n_bit_timer;
            r_wait_timer <= n_wait_timer;
            r_bits_left  <= n_bits_left;
            r_shift      <= n_shift;
        end
    end

endmodule

// ----- rtl/urx_out_reg.sv -----
module urx_out_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  urx_pkg::t_result              i_result,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [urx_pkg::C_BYTE_W-1:0]  o_data,
    output logic                          o_timed_out
);
    import urx_pkg::*;

    logic                r_valid;
    logic [C_BYTE_W-1:0] r_data;
    logic                r_timed_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_result.emit;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.emit) begin
            r_data      <= i_result.data;
            r_timed_out <= i_result.timed_out;
        end
    end

    assign o_valid     = r_valid;
    assign o_data      = r_data;
    assign o_timed_out = r_timed_out;

endmodule

// ----- rtl/uart_rx_8n1_with_timeout.sv -----
// A line sample is held in the input register; the receiver steps on it once the result
//   register can take what it yields, and the result beat is offered from that register.
// Throughput: one line sample per cycle while results are taken; the input register and the result
//   register each hold one beat, so a stalled result does not stop intake at once.
// Reset (i_rst_n low, synchronous): idle with no request, timers cleared,
//   bit_ticks 16, half_bit_ticks 8, timeout_ticks 1000000.
`include "uart_rx_8n1_with_timeout_assert.svh"

module uart_rx_8n1_with_timeout #(
    parameter int DATA_BITS = urx_pkg::C_DATA_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [urx_pkg::C_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [urx_pkg::C_CFG_DAT_W-1:0]  i_cfg_wdata,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [0] start_req, [1] rx_level, [7:2] zero
    input  logic [7:0]                       i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [7:0] data
    output logic [urx_pkg::C_BYTE_W-1:0]     o_m_axis_tdata,
    // [0] timed_out
    output logic                             o_m_axis_tuser
);
    import urx_pkg::*;

    t_item   w_in_item;
    t_item   w_item;
    logic    w_in_valid;
    logic    w_advance;
    t_result w_result;

    assign w_in_item.start_req = i_s_axis_tdata[0];
    assign w_in_item.rx_level  = i_s_axis_tdata[1];

    // step the receiver once the result register can take what it yields
    assign w_advance = w_in_valid && (!o_m_axis_tvalid || i_m_axis_tready);

    urx_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (w_in_item),
        .i_drain (w_advance),
        .o_valid (w_in_valid),
        .o_item  (w_item)
    );

    urx_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_advance),
        .i_item      (w_item),
        .o_result    (w_result)
    );

    urx_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_advance),
        .i_result    (w_result),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata),
        .o_timed_out (o_m_axis_tuser)
    );

    `URX_ASSERT_NOW(a_timeout_zero_data, o_m_axis_tvalid && o_m_axis_tuser,
        o_m_axis_tdata == '0, "timeout beat with nonzero data")
    `URX_ASSERT_NOW(a_full_blocks_intake, o_m_axis_tvalid && !i_m_axis_tready && w_in_valid,
        !o_s_axis_tready, "intake open while both stages are full")
    `URX_ASSERT_NEXT(a_accept_fills, i_s_axis_tvalid && o_s_axis_tready,
        w_in_valid, "accepted beat not held in the input stage")

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import urx_pkg::*;

    typedef struct packed {
        logic [C_BYTE_W-1:0] data;
        logic                timed_out;
    } t_rx_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [C_CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [C_CFG_DAT_W-1:0] i_cfg_wdata = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // [0] start_req, [1] rx_level, [7:2] zero
    logic [7:0]             i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [7:0] data
    logic [C_BYTE_W-1:0]    o_m_axis_tdata;
    // [0] timed_out
    logic                   o_m_axis_tuser;

    // Sink controls, written with <= so the result process sees them cleanly; src_gaps_on gates source gaps.
    logic sink_hold = 1'b0;
    logic sink_gaps_on = 1'b1;
    bit   src_gaps_on = 1'b1;

    // Predicted receiver state and register copies.
    t_phase                 rx_phase = PH_IDLE;
    logic [C_BIT_W-1:0]     bit_cnt = '0;
    logic [C_WAIT_W-1:0]    wait_cnt = '0;
    logic [C_CNT_W-1:0]     bits_left = '0;
    logic [C_BYTE_W-1:0]    shift_reg = '0;
    logic [C_BIT_W-1:0]     cfg_bit_ticks = C_BIT_TICKS_RST;
    logic [C_BIT_W-1:0]     cfg_half_ticks = C_HALF_TICKS_RST;
    logic [C_WAIT_W-1:0]    cfg_timeout = C_TIMEOUT_RST;

    t_rx_result awaited_bytes[$];
    int         mismatch_cnt = 0;
    int         samples_counted = 0;

    uart_rx_8n1_with_timeout #(
        .DATA_BITS(C_DATA_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    initial forever #6 i_clk = ~i_clk;

    initial begin
        #(64'd4_000_000);
        $display("uart_rx_8n1_with_timeout test failed");
        $finish;
    end

    function automatic void predict_line_sample(input logic req, input logic level);
        logic [C_BIT_W-1:0] bit_period;
        logic [C_CNT_W-1:0] pos;
        t_rx_result         res;
        logic               emit;
        bit_period = (cfg_bit_ticks == '0) ? C_BIT_W'(1) : cfg_bit_ticks;
        emit = 1'b0;
        res = '0;
        if (req || rx_phase != PH_IDLE) samples_counted++;
        if (req) begin
            rx_phase = PH_WAIT_HIGH;
            bit_cnt = '0;
            wait_cnt = '0;
            bits_left = '0;
            shift_reg = '0;
        end
        case (rx_phase)
            PH_WAIT_HIGH, PH_WAIT_EDGE: begin
                if (rx_phase == PH_WAIT_HIGH && level) begin
                    rx_phase = PH_WAIT_EDGE;
                    wait_cnt = '0;
                end else if (rx_phase == PH_WAIT_EDGE && !level) begin
                    wait_cnt = '0;
                    bits_left = C_CNT_W'(C_DATA_BITS);
                    shift_reg = '0;
                    if (cfg_half_ticks == '0) begin
                        rx_phase = PH_BITS;
                        bit_cnt = bit_period;
                    end else begin
                        rx_phase = PH_HALF;
                        bit_cnt = cfg_half_ticks;
                    end
                end else begin
                    wait_cnt = wait_cnt + 1'b1;
                    if (wait_cnt >= cfg_timeout) begin
                        rx_phase = PH_IDLE;
                        wait_cnt = '0;
                        res.timed_out = 1'b1;
                        emit = 1'b1;
                    end
                end
            end
            PH_HALF: begin
                bit_cnt = bit_cnt - 1'b1;
                if (bit_cnt == '0) begin
                    rx_phase = PH_BITS;
                    bit_cnt = bit_period;
                end
            end
            PH_BITS: begin
                bit_cnt = bit_cnt - 1'b1;
                if (bit_cnt == '0) begin
                    pos = C_CNT_W'(C_DATA_BITS) - bits_left;
                    // bits past the eighth are sampled but dropped
                    if (level && pos < 8) shift_reg[pos[2:0]] = 1'b1;
                    bits_left = bits_left - 1'b1;
                    if (bits_left != '0) begin
                        bit_cnt = bit_period;
                    end else begin
                        rx_phase = PH_IDLE;
                        bit_cnt = '0;
                        res.data = shift_reg;
                        emit = 1'b1;
                    end
                end
            end
            default: rx_phase = PH_IDLE;
        endcase
        if (emit) awaited_bytes.push_back(res);
    endfunction

    task automatic send_sample(input logic req, input logic level);
        if (src_gaps_on && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {6'b0, level, req};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_line_sample(req, level);
    endtask

    // Hold the sender until every predicted result has been seen.
    task automatic wait_results_done();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (awaited_bytes.size() != 0);
    endtask

    task automatic write_reg(input logic [C_CFG_IDX_W-1:0] idx, input int value);
        // finish any reception in flight so the write lands while idle
        while (rx_phase != PH_IDLE)
            send_sample(1'b0, (rx_phase == PH_WAIT_HIGH) ? 1'b1 :
                              (rx_phase == PH_WAIT_EDGE) ? 1'b0 : 1'($urandom_range(0, 1)));
        wait_results_done();
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= C_CFG_DAT_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            C_CFG_BIT_TICKS:  cfg_bit_ticks = value[C_BIT_W-1:0];
            C_CFG_HALF_TICKS: cfg_half_ticks = value[C_BIT_W-1:0];
            C_CFG_TIMEOUT:    cfg_timeout = value[C_WAIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_line_timing(input int bit_ticks, input int half_ticks, input int timeout);
        write_reg(C_CFG_BIT_TICKS, bit_ticks);
        write_reg(C_CFG_HALF_TICKS, half_ticks);
        write_reg(C_CFG_TIMEOUT, timeout);
    endtask

    // One serial frame shaped for the current register settings; cut_short drops its tail.
    task automatic send_frame(input logic [7:0] value, input bit cut_short);
        int   bit_period;
        int   n_ticks;
        int   cut_at;
        int   slot;
        logic lead;
        logic level;
        bit_period = (cfg_bit_ticks == '0) ? 1 : int'(cfg_bit_ticks);
        n_ticks = int'(cfg_half_ticks) + 8 * bit_period;
        cut_at = cut_short ? $urandom_range(0, n_ticks - 1) : n_ticks;
        lead = ($urandom_range(0, 3) != 0);
        send_sample(1'b1, lead);
        if (!lead) begin
            repeat ($urandom_range(0, 1)) send_sample(1'b0, 1'b0);
            send_sample(1'b0, 1'b1);
        end
        repeat ($urandom_range(0, 2)) send_sample(1'b0, 1'b1);
        send_sample(1'b0, 1'b0);
        for (int t = 1; t <= cut_at; t++) begin
            if (t <= int'(cfg_half_ticks)) begin
                level = 1'($urandom_range(0, 1));
            end else begin
                slot = (t - int'(cfg_half_ticks) - 1) / bit_period;
                level = value[slot];
            end
            send_sample(1'b0, level);
        end
        if (!cut_short) repeat ($urandom_range(1, 2)) send_sample(1'b0, 1'b1);
    endtask

    task automatic test_reset_defaults();
        // no request yet: these are dropped
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b1);
        send_frame(8'hA5, 1'b0);
    endtask

    task automatic test_short_frames();
        set_line_timing(1, 0, 2);
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
        repeat (8) send_sample(1'b0, 1'b1);
        // restart in the middle of a byte, then receive all zeros
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
        repeat (8) send_sample(1'b0, 1'b0);
    endtask

    task automatic test_wait_timeouts();
        write_reg(C_CFG_TIMEOUT, 0);
        send_sample(1'b1, 1'b0);
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b1);
        write_reg(C_CFG_TIMEOUT, 3);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b1);
        repeat (3) send_sample(1'b0, 1'b1);
        // a new request restarts the idle wait count
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b0);
    endtask

    task automatic test_register_extremes();
        logic [7:0] pattern;
        pattern = 8'h5A;
        write_reg(C_CFG_BIT_TICKS, 0);
        write_reg(C_CFG_HALF_TICKS, 3);
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
        repeat (3) send_sample(1'b0, 1'b1);
        for (int k = 0; k < 8; k++) send_sample(1'b0, pattern[k]);
        // longest timers: start a byte, abandon it and leave through a timeout
        set_line_timing(65535, 65535, 2);
        send_sample(1'b1, 1'b1);
        repeat (4) send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
        write_reg(C_CFG_HALF_TICKS, 0);
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
        repeat (3) send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
        write_reg(C_CFG_TIMEOUT, 24'hFFFFFF);
        write_reg(C_CFG_BIT_TICKS, 1);
        pattern = 8'h81;
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
        for (int k = 0; k < 8; k++) send_sample(1'b0, pattern[k]);
    endtask

    task automatic test_backpressure();
        write_reg(C_CFG_TIMEOUT, 1);
        src_gaps_on = 1'b0;
        // every request on a low line times out at once, so results pile up
        fork
            begin
                sink_hold <= 1'b1;
                repeat (150) @(posedge i_clk);
                sink_hold <= 1'b0;
            end
            for (int k = 0; k < 40; k++) send_sample(1'b1, 1'b0);
        join
        wait_results_done();
        src_gaps_on = 1'b1;
        repeat (20) send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int sel;
        int bt;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 0) begin
                set_line_timing(1, 0, 1);
            end else if (ph == 1) begin
                set_line_timing(2, 1, 3);
            end else if (ph == 5) begin
                set_line_timing(3, 1, 8);
                src_gaps_on = 1'b0;
                sink_gaps_on <= 1'b0;
            end else begin
                bt = $urandom_range(1, 6);
                set_line_timing(bt, $urandom_range(0, 2 * bt), $urandom_range(1, 24));
            end
            stop_at = samples_counted + 205;
            while (samples_counted < stop_at) begin
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    send_frame(8'($urandom_range(0, 255)), 1'b0);
                else if (sel == 7)
                    send_frame(8'($urandom_range(0, 255)), 1'b1);
                else
                    repeat ($urandom_range(1, 10))
                        send_sample($urandom_range(0, 5) == 0, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin : result_sink
        t_rx_result got;
        t_rx_result want;
        int         stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                got.data = o_m_axis_tdata;
                got.timed_out = o_m_axis_tuser;
                if (awaited_bytes.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected beat at %0t: data %02h timed_out %0b",
                                 $time, got.data, got.timed_out);
                end else begin
                    want = awaited_bytes.pop_front();
                    if (got.data !== want.data || got.timed_out !== want.timed_out) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"mismatch at %0t: expected data %02h timed_out %0b,",
                                      " got data %02h timed_out %0b"},
                                     $time, want.data, want.timed_out,
                                     got.data, got.timed_out);
                    end
                end
            end
            if (sink_hold) begin
                i_m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else if (sink_gaps_on && $urandom_range(0, 4) == 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_short_frames();
        test_wait_timeouts();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();
        wait_results_done();
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0 && awaited_bytes.size() == 0)
            $display("uart_rx_8n1_with_timeout test passed");
        else
            $display("uart_rx_8n1_with_timeout test failed");
        $finish;
    end

endmodule

// ----- uart_rx_8n1_with_timeout.f -----
+incdir+rtl
rtl/urx_pkg.sv
rtl/urx_in_reg.sv
rtl/urx_core.sv
rtl/urx_out_reg.sv
rtl/uart_rx_8n1_with_timeout.sv
tb/sv/tb.sv
